// File: sv/die_pkg.sv
`timescale 1ns / 1ps
package die_pkg;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc;
        logic        thumb_mode;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [31:0] lo_value;
        logic [31:0] hi_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  error_code;
        logic [31:0] next_pc;
        logic        write_lo;
        logic [3:0]  lo_index;
        logic [31:0] lo_data;
        logic        write_hi;
        logic [3:0]  hi_index;
        logic [31:0] hi_data;
        logic        q_set;
    } t_out_item;

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_NO_ROM   = 4'd1,
        ERR_PC_RANGE = 4'd2,
        ERR_ZERO     = 4'd3,
        ERR_THUMB    = 4'd4,
        ERR_DISABLED = 4'd5,
        ERR_NOT_DSP  = 4'd6,
        ERR_BAD_REG  = 4'd7,
        ERR_BAD_OP   = 4'd8,
        ERR_BAD_GRP  = 4'd9
    } t_err;

    typedef enum logic [2:0] {
        K_ERROR, K_SMULL, K_SMLAL, K_UMAAL, K_SAT, K_PACK
    } t_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [31:0] npc;
        logic [3:0]  opc;
        logic [1:0]  rot;
        logic [3:0]  a_d;
        logic [3:0]  a_h;
        logic [31:0] rn;
        logic [31:0] rm;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_op;

    localparam logic [7:0]  DSP_TAG    = 8'hFA;
    localparam logic [3:0]  OP_SMULL   = 4'b0000;
    localparam logic [3:0]  OP_SMLAL   = 4'b0100;
    localparam logic [3:0]  OP_UMAAL   = 4'b0110;
    localparam logic [3:0]  REG_PC     = 4'hF;
    localparam logic [1:0]  ADDR_EN    = 2'd0;
    localparam logic [1:0]  ADDR_ROM   = 2'd1;

endpackage

// File: sv/die_front.sv
`timescale 1ns / 1ps
module die_front (
    input  logic              i_dsp_enable,
    input  logic [31:0]       i_rom_size,
    input  die_pkg::t_in_item i_item,
    output die_pkg::t_op      o_op
);
    logic [31:0] w;
    logic [2:0]  grp;
    logic [3:0]  opc, a_n, a_d, a_h, a_m;
    logic [31:0] npc, pc3;
    logic        bad_mul, bad_3;

    assign w   = i_item.instruction;
    assign grp = w[22:20];
    assign opc = w[7:4];
    assign a_n = w[19:16];
    assign a_d = w[15:12];
    assign a_h = w[11:8];
    assign a_m = w[3:0];
    assign npc = i_item.pc + 32'd4;
    assign pc3 = i_item.pc + 32'd3;
    assign bad_3 = (a_d == die_pkg::REG_PC) || (a_n == die_pkg::REG_PC)
        || (a_m == die_pkg::REG_PC);
    assign bad_mul = bad_3 || (a_h == die_pkg::REG_PC) || (a_d == a_h);

    always_comb begin
        o_op.kind = die_pkg::K_ERROR;
        o_op.err  = die_pkg::ERR_OK;
        o_op.npc  = npc;
        o_op.opc  = opc;
        o_op.rot  = w[7:6];
        o_op.a_d  = a_d;
        o_op.a_h  = a_h;
        o_op.rn   = i_item.rn_value;
        o_op.rm   = i_item.rm_value;
        o_op.lo   = i_item.lo_value;
        o_op.hi   = i_item.hi_value;
        if (i_rom_size == 32'd0) begin
            o_op.err = die_pkg::ERR_NO_ROM;
            o_op.npc = i_item.pc;
        end else if (pc3 >= i_rom_size) begin
            o_op.err = die_pkg::ERR_PC_RANGE;
            o_op.npc = i_item.pc;
        end else if (w == 32'd0) begin
            o_op.err = die_pkg::ERR_ZERO;
        end else if (!i_item.thumb_mode) begin
            o_op.err = die_pkg::ERR_THUMB;
            o_op.npc = i_item.pc;
        end else if (!i_dsp_enable) begin
            o_op.err = die_pkg::ERR_DISABLED;
            o_op.npc = i_item.pc;
        end else if (w[31:24] != die_pkg::DSP_TAG) begin
            o_op.err = die_pkg::ERR_NOT_DSP;
        end else begin
            case (grp)
                3'd0: begin
                    if (bad_mul) o_op.err = die_pkg::ERR_BAD_REG;
                    else if (opc == die_pkg::OP_SMULL) o_op.kind = die_pkg::K_SMULL;
                    else if (opc == die_pkg::OP_SMLAL) o_op.kind = die_pkg::K_SMLAL;
                    else if (opc == die_pkg::OP_UMAAL) o_op.kind = die_pkg::K_UMAAL;
                    else o_op.err = die_pkg::ERR_BAD_OP;
                end
                3'd1: begin
                    if (bad_3) o_op.err = die_pkg::ERR_BAD_REG;
                    else if (opc > 4'd3) o_op.err = die_pkg::ERR_BAD_OP;
                    else o_op.kind = die_pkg::K_SAT;
                end
                3'd2: begin
                    if (bad_3) o_op.err = die_pkg::ERR_BAD_REG;
                    else if (opc == 4'd0 || opc == 4'd1 || (opc >= 4'd4 && opc <= 4'd7))
                        o_op.kind = die_pkg::K_PACK;
                    else o_op.err = die_pkg::ERR_BAD_OP;
                end
                default: o_op.err = die_pkg::ERR_BAD_GRP;
            endcase
        end
    end
endmodule

// File: sv/die_queue.sv
`timescale 1ns / 1ps
module die_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

// File: sv/die_back.sv
`timescale 1ns / 1ps
module die_back (
    input  die_pkg::t_op      i_op,
    output die_pkg::t_out_item o_res
);
    logic signed [32:0] sa, sb;
    logic signed [65:0] prod;
    logic [63:0] r64;
    logic signed [33:0] b, s;
    logic signed [33:0] bs;
    logic [31:0] res, v, shl;
    logic q;
    logic [4:0] sh;

    localparam logic signed [33:0] SMAX = 34'sh07FFFFFFF;
    localparam logic signed [33:0] SMIN = -34'sh080000000;

    always_comb begin
        // one 33x33 multiplier covers signed and unsigned forms
        if (i_op.kind == die_pkg::K_UMAAL) begin
            sa = {1'b0, i_op.rn}; sb = {1'b0, i_op.rm};
        end else begin
            sa = {i_op.rn[31], i_op.rn}; sb = {i_op.rm[31], i_op.rm};
        end
        prod = sa * sb;
        case (i_op.kind)
            die_pkg::K_SMLAL: r64 = {i_op.hi, i_op.lo} + prod[63:0];
            die_pkg::K_UMAAL: r64 = prod[63:0] + {32'd0, i_op.hi} + {32'd0, i_op.lo};
            default:          r64 = prod[63:0];
        endcase

        q = 1'b0;
        b = {{2{i_op.rm[31]}}, i_op.rm};
        if (i_op.opc[1]) begin
            bs = b <<< 1;
            if (bs > SMAX) begin bs = SMAX; q = 1'b1; end
            else if (bs < SMIN) begin bs = SMIN; q = 1'b1; end
        end else begin
            bs = b;
        end
        s = i_op.opc[0] ? ({{2{i_op.rn[31]}}, i_op.rn} - bs)
                        : ({{2{i_op.rn[31]}}, i_op.rn} + bs);
        if (s > SMAX) begin s = SMAX; q = 1'b1; end
        else if (s < SMIN) begin s = SMIN; q = 1'b1; end

        sh  = {i_op.rot, 3'b000};
        v   = i_op.rm >> sh;
        shl = i_op.rm << sh;
        case (i_op.opc)
            4'd0:    res = {shl[31:16], i_op.rn[15:0]};
            4'd1:    res = {i_op.rn[31:16], v[15:0]};
            4'd4:    res = {{24{v[7]}}, v[7:0]};
            4'd5:    res = {24'd0, v[7:0]};
            4'd6:    res = {{16{v[15]}}, v[15:0]};
            default: res = {16'd0, v[15:0]};
        endcase

        o_res = '0;
        o_res.error_code = i_op.err;
        o_res.next_pc    = i_op.npc;
        case (i_op.kind)
            die_pkg::K_SMULL, die_pkg::K_SMLAL, die_pkg::K_UMAAL: begin
                o_res.write_lo = 1'b1; o_res.lo_index = i_op.a_d;
                o_res.lo_data  = r64[31:0];
                o_res.write_hi = 1'b1; o_res.hi_index = i_op.a_h;
                o_res.hi_data  = r64[63:32];
            end
            die_pkg::K_SAT: begin
                o_res.write_lo = 1'b1; o_res.lo_index = i_op.a_d;
                o_res.lo_data  = s[31:0]; o_res.q_set = q;
            end
            die_pkg::K_PACK: begin
                o_res.write_lo = 1'b1; o_res.lo_index = i_op.a_d;
                o_res.lo_data  = res;
            end
            default: ;
        endcase
    end
endmodule

// File: sv/dsp_instruction_execute.sv
`timescale 1ns / 1ps
// DSP execute unit: one instruction item enters per clock while full is low. Its
// result is registered in the input queue and then in the result queue before it
// is on the output ports to be popped. The front classifies the word and
// runs the error checks combinationally into a two-entry queue; the back
// executes from the queue head (one 33x33 multiply) into a two-entry result
// queue, so the throughput is one item per clock as long as pop keeps up.
module dsp_instruction_execute (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  die_pkg::t_in_item     i_in,
    output logic                  empty,
    input  logic                  pop,
    output die_pkg::t_out_item    o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic        r_dsp_enable;
    logic [31:0] r_rom_size;
    die_pkg::t_op       op_f, op_b;
    die_pkg::t_out_item res_b;
    logic opq_empty, resq_full;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsp_enable <= 1'b0;
            r_rom_size   <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'b0 && paddr[1:0] == 2'b00) begin
                if (paddr[2:2] == die_pkg::ADDR_EN[0:0]) r_dsp_enable <= pwdata[0];
            end
            if (paddr[2] == 1'b1 && paddr[1:0] == 2'b00) begin
                if (paddr[2:2] == die_pkg::ADDR_ROM[0:0]) r_rom_size <= pwdata;
            end
        end
    end

    always_comb begin
        case (paddr)
            {die_pkg::ADDR_EN[0:0], 2'b00}:  prdata = {31'd0, r_dsp_enable};
            {die_pkg::ADDR_ROM[0:0], 2'b00}: prdata = r_rom_size;
            default:                         prdata = '0;
        endcase
    end

    die_front u_front (
        .i_dsp_enable(r_dsp_enable), .i_rom_size(r_rom_size),
        .i_item(i_in), .o_op(op_f)
    );

    die_queue #(.WIDTH($bits(die_pkg::t_op)), .DEPTH(2)) u_opq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(op_f), .o_full(full),
        .i_pop(!resq_full), .o_empty(opq_empty), .o_data(op_b)
    );

    die_back u_back (.i_op(op_b), .o_res(res_b));

    die_queue #(.WIDTH($bits(die_pkg::t_out_item)), .DEPTH(2)) u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(!opq_empty), .i_data(res_b), .o_full(resq_full),
        .i_pop(pop), .o_empty(empty), .o_data(o_out)
    );
endmodule

// File: sv/die_checker.sv
`timescale 1ns / 1ps
module die_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input die_pkg::t_out_item o_out
);
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result queue not empty after reset");
    a_not_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !full) else $error("input full after reset");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_out)) else $error("waiting result changed");
    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.error_code != die_pkg::ERR_OK) |->
        (!o_out.write_lo && !o_out.write_hi && !o_out.q_set))
        else $error("error item carries write-back");
    a_hi_needs_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.write_hi) |-> o_out.write_lo)
        else $error("high write without low write");
endmodule

bind dsp_instruction_execute die_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_out(o_out)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam logic [3:0] OP_QADD  = 4'd0;
    localparam logic [3:0] OP_QSUB  = 4'd1;
    localparam logic [3:0] OP_QDADD = 4'd2;
    localparam logic [3:0] OP_QDSUB = 4'd3;
    localparam logic [3:0] OP_PKHBT = 4'd0;
    localparam logic [3:0] OP_PKHTB = 4'd1;
    localparam logic [3:0] OP_SXTB  = 4'd4;
    localparam logic [3:0] OP_UXTB  = 4'd5;
    localparam logic [3:0] OP_SXTH  = 4'd6;
    localparam logic [3:0] OP_UXTH  = 4'd7;
    localparam logic [2:0] GRP_MUL  = 3'd0;
    localparam logic [2:0] GRP_SAT  = 3'd1;
    localparam logic [2:0] GRP_PACK = 3'd2;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    die_pkg::t_in_item i_in = '0;
    logic empty;
    logic pop = 1'b0;
    die_pkg::t_out_item o_out;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    int cycles = 0;
    int n_sent = 0;
    bit hold_off = 1'b0;

    dsp_instruction_execute i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    class exec_board;
        die_pkg::t_out_item pending[$];
        logic en;
        logic [31:0] rom;
        int errors;
        int now;
        int err_seen[16];

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, now);
            errors++;
        endtask

        function logic [31:0] sat(input logic signed [63:0] v, inout logic q);
            if (v > 64'sd2147483647) begin
                q = 1'b1;
                return 32'h7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                q = 1'b1;
                return 32'h80000000;
            end
            return v[31:0];
        endfunction

        function die_pkg::t_out_item execute(input die_pkg::t_in_item it);
            die_pkg::t_out_item r;
            logic [31:0] w, npc, v, shl, res;
            logic [3:0] opc, a_n, a_d, a_h, a_m;
            logic [2:0] grp;
            logic [63:0] p;
            logic signed [63:0] sn, sm, b, s;
            logic [4:0] sh;
            logic q;
            w = it.instruction;
            npc = it.pc + 32'd4;
            grp = w[22:20];
            opc = w[7:4];
            a_n = w[19:16]; a_d = w[15:12]; a_h = w[11:8]; a_m = w[3:0];
            sn = $signed(it.rn_value);
            sm = $signed(it.rm_value);
            r = '0;
            q = 1'b0;
            res = '0;
            r.next_pc = npc;
            if (rom == 32'd0) begin
                r.error_code = die_pkg::ERR_NO_ROM; r.next_pc = it.pc; return r;
            end
            if (it.pc + 32'd3 >= rom) begin
                r.error_code = die_pkg::ERR_PC_RANGE; r.next_pc = it.pc; return r;
            end
            if (w == 32'd0) begin
                r.error_code = die_pkg::ERR_ZERO; return r;
            end
            if (!it.thumb_mode) begin
                r.error_code = die_pkg::ERR_THUMB; r.next_pc = it.pc; return r;
            end
            if (!en) begin
                r.error_code = die_pkg::ERR_DISABLED; r.next_pc = it.pc; return r;
            end
            if (w[31:24] != die_pkg::DSP_TAG) begin
                r.error_code = die_pkg::ERR_NOT_DSP; return r;
            end
            if (grp == GRP_MUL) begin
                if (a_d == die_pkg::REG_PC || a_h == die_pkg::REG_PC
                    || a_n == die_pkg::REG_PC || a_m == die_pkg::REG_PC || a_d == a_h) begin
                    r.error_code = die_pkg::ERR_BAD_REG; return r;
                end
                if (opc == die_pkg::OP_SMULL)
                    p = sn * sm;
                else if (opc == die_pkg::OP_SMLAL)
                    p = {it.hi_value, it.lo_value} + sn * sm;
                else if (opc == die_pkg::OP_UMAAL)
                    p = {32'd0, it.rn_value} * {32'd0, it.rm_value}
                        + {32'd0, it.hi_value} + {32'd0, it.lo_value};
                else begin
                    r.error_code = die_pkg::ERR_BAD_OP; return r;
                end
                res = p[31:0];
                r.write_hi = 1'b1;
                r.hi_index = a_h;
                r.hi_data = p[63:32];
            end else if (grp == GRP_SAT || grp == GRP_PACK) begin
                if (a_d == die_pkg::REG_PC || a_n == die_pkg::REG_PC
                    || a_m == die_pkg::REG_PC) begin
                    r.error_code = die_pkg::ERR_BAD_REG; return r;
                end
                if (grp == GRP_SAT) begin
                    if (opc > OP_QDSUB) begin
                        r.error_code = die_pkg::ERR_BAD_OP; return r;
                    end
                    b = sm;
                    if (opc >= OP_QDADD)
                        b = $signed(sat(b * 64'sd2, q));
                    s = opc[0] ? sn - b : sn + b;
                    res = sat(s, q);
                end else begin
                    sh = {w[7:6], 3'b000};
                    v = it.rm_value >> sh;
                    shl = it.rm_value << sh;
                    case (opc)
                        OP_PKHBT: res = {shl[31:16], it.rn_value[15:0]};
                        OP_PKHTB: res = {it.rn_value[31:16], v[15:0]};
                        OP_SXTB:  res = {{24{v[7]}}, v[7:0]};
                        OP_UXTB:  res = {24'd0, v[7:0]};
                        OP_SXTH:  res = {{16{v[15]}}, v[15:0]};
                        OP_UXTH:  res = {16'd0, v[15:0]};
                        default: begin
                            r.error_code = die_pkg::ERR_BAD_OP; return r;
                        end
                    endcase
                end
            end else begin
                r.error_code = die_pkg::ERR_BAD_GRP; return r;
            end
            r.error_code = die_pkg::ERR_OK;
            r.write_lo = 1'b1;
            r.lo_index = a_d;
            r.lo_data = res;
            r.q_set = q;
            return r;
        endfunction

        function void note_instruction(input die_pkg::t_in_item it);
            pending.push_back(execute(it));
        endfunction

        task check_result(input die_pkg::t_out_item got, input int cyc);
            die_pkg::t_out_item want;
            now = cyc;
            if (pending.size() == 0) begin
                report("unexpected item", got.lo_data, 32'd0);
                return;
            end
            want = pending.pop_front();
            err_seen[want.error_code]++;
            if (got.error_code !== want.error_code)
                report("error_code", 32'(got.error_code), 32'(want.error_code));
            if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
            if (got.write_lo !== want.write_lo)
                report("write_lo", 32'(got.write_lo), 32'(want.write_lo));
            if (got.lo_index !== want.lo_index)
                report("lo_index", 32'(got.lo_index), 32'(want.lo_index));
            if (got.lo_data !== want.lo_data) report("lo_data", got.lo_data, want.lo_data);
            if (got.write_hi !== want.write_hi)
                report("write_hi", 32'(got.write_hi), 32'(want.write_hi));
            if (got.hi_index !== want.hi_index)
                report("hi_index", 32'(got.hi_index), 32'(want.hi_index));
            if (got.hi_data !== want.hi_data) report("hi_data", got.hi_data, want.hi_data);
            if (got.q_set !== want.q_set) report("q_set", 32'(got.q_set), 32'(want.q_set));
        endtask
    endclass

    exec_board board = new();

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // accepted items go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) board.note_instruction(i_in);
        if (i_rst_n && pop && !empty) board.check_result(o_out, cycles);
    end

    // receiver stall pattern, with a long hold-off when requested
    always @(posedge i_clk) begin
        int phase;
        phase = cycles % 64;
        if (hold_off) pop <= 1'b0;
        else if (phase < 20) pop <= 1'b1;
        else if (phase < 40) pop <= ($urandom_range(3) != 0);
        else pop <= ($urandom_range(1) != 0);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx[0], 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        board.en = (idx == die_pkg::ADDR_EN) ? val[0] : board.en;
        board.rom = (idx == die_pkg::ADDR_ROM) ? val : board.rom;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send(input die_pkg::t_in_item it);
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    task automatic idle(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'hFFFFFFFF;
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic die_pkg::t_in_item good_item(input logic [2:0] grp,
                                                    input logic [3:0] opc);
        die_pkg::t_in_item it;
        it.instruction = {die_pkg::DSP_TAG, 1'b0, grp, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
        it.instruction[19:16] = 4'($urandom_range(14));
        it.instruction[15:12] = 4'($urandom_range(14));
        it.instruction[11:8] = 4'($urandom_range(14));
        it.instruction[3:0] = 4'($urandom_range(14));
        // rotation shares bits 7:6 with the operation field
        it.instruction[7:4] = opc;
        if (grp == GRP_MUL && it.instruction[15:12] == it.instruction[11:8])
            it.instruction[11:8] = it.instruction[15:12] ^ 4'd1;
        it.pc = $urandom_range(32'h0000FF00) & 32'hFFFFFFFC;
        it.thumb_mode = 1'b1;
        it.rn_value = rnd_val();
        it.rm_value = rnd_val();
        it.lo_value = rnd_val();
        it.hi_value = rnd_val();
        return it;
    endfunction

    function automatic die_pkg::t_in_item any_ok_item();
        case ($urandom_range(2))
            0: begin
                case ($urandom_range(2))
                    0: return good_item(GRP_MUL, die_pkg::OP_SMULL);
                    1: return good_item(GRP_MUL, die_pkg::OP_SMLAL);
                    default: return good_item(GRP_MUL, die_pkg::OP_UMAAL);
                endcase
            end
            1: return good_item(GRP_SAT, 4'($urandom_range(3)));
            default: begin
                case ($urandom_range(5))
                    0: return good_item(GRP_PACK, OP_PKHBT);
                    1: return good_item(GRP_PACK, OP_PKHTB);
                    default: return good_item(GRP_PACK, 4'($urandom_range(4, 7)));
                endcase
            end
        endcase
    endfunction

    function automatic die_pkg::t_in_item rnd_item();
        die_pkg::t_in_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) return any_ok_item();
        it = any_ok_item();
        case (pick % 6)
            0: it.instruction = $urandom();
            1: it.instruction[$urandom_range(19, 0)] ^= 1'b1;
            2: it.instruction[22:20] = 3'($urandom_range(7));
            3: it.instruction[7:4] = 4'($urandom());
            4: it.thumb_mode = 1'($urandom_range(1));
            default: it.pc = $urandom();
        endcase
        if ($urandom_range(30) == 0) it.instruction = '0;
        return it;
    endfunction

    task automatic burst_phase(input int n);
        int k, gap;
        k = 0;
        while (k < n) begin
            gap = $urandom_range(6);
            repeat ($urandom_range(1, 12)) begin
                if (k < n) begin
                    send(rnd_item());
                    k++;
                end
            end
            if (gap > 2) idle(gap - 2);
        end
        push <= 1'b0;
    endtask

    initial begin
        die_pkg::t_in_item it;
        board.en = 1'b0;
        board.rom = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: no memory at all
        send(good_item(GRP_SAT, OP_QADD));
        idle(1);
        drain();
        reg_write(die_pkg::ADDR_ROM, 32'hFFFFFFFF);
        // disabled extension
        send(good_item(GRP_SAT, OP_QADD));
        idle(1);
        drain();
        reg_write(die_pkg::ADDR_EN, 32'd1);

        // directed: every operation, the multiply and saturating ones with corner operands
        it = good_item(GRP_MUL, die_pkg::OP_SMULL);
        it.rn_value = 32'h80000000; it.rm_value = 32'h80000000; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMLAL);
        it.hi_value = 32'hFFFFFFFF; it.lo_value = 32'hFFFFFFFF; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_UMAAL);
        it.rn_value = '1; it.rm_value = '1; it.hi_value = '1; it.lo_value = '1; send(it);
        it = good_item(GRP_SAT, OP_QADD);
        it.rn_value = 32'h7FFFFFFF; it.rm_value = 32'h1; send(it);
        it = good_item(GRP_SAT, OP_QSUB);
        it.rn_value = 32'h80000000; it.rm_value = 32'h1; send(it);
        it = good_item(GRP_SAT, OP_QDADD);
        it.rn_value = 32'h0; it.rm_value = 32'h40000000; send(it);
        it = good_item(GRP_SAT, OP_QDSUB);
        it.rn_value = 32'h7FFFFFFF; it.rm_value = 32'h80000000; send(it);
        send(good_item(GRP_PACK, OP_PKHBT));
        send(good_item(GRP_PACK, OP_PKHTB));
        send(good_item(GRP_PACK, OP_SXTB));
        send(good_item(GRP_PACK, OP_UXTB));
        send(good_item(GRP_PACK, OP_SXTH));
        send(good_item(GRP_PACK, OP_UXTH));
        // error cases in check order
        it = good_item(GRP_MUL, die_pkg::OP_SMULL); it.pc = 32'hFFFFFFFD; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMULL); it.instruction = '0; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMULL); it.thumb_mode = 1'b0; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMULL); it.instruction[31:24] = 8'hFB; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMULL);
        it.instruction[11:8] = it.instruction[15:12];
        send(it);
        it = good_item(GRP_SAT, OP_QADD); it.instruction[3:0] = die_pkg::REG_PC; send(it);
        it = good_item(GRP_MUL, die_pkg::OP_SMULL); it.instruction[7:4] = 4'd1; send(it);
        it = good_item(GRP_SAT, OP_QADD); it.instruction[7:4] = 4'd15; send(it);
        it = good_item(GRP_PACK, OP_SXTB); it.instruction[7:4] = 4'd2; send(it);
        it = good_item(GRP_SAT, OP_QADD); it.instruction[22:20] = 3'd7; send(it);
        push <= 1'b0;
        drain();

        // long stall on the receiver so the block fills and backs up
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            burst_phase(40);
        join
        drain();

        burst_phase(300);
        drain();
        reg_write(die_pkg::ADDR_ROM, 32'h00008000);
        burst_phase(250);
        drain();
        reg_write(die_pkg::ADDR_ROM, 32'd4);
        burst_phase(20);
        drain();
        reg_write(die_pkg::ADDR_EN, 32'd0);
        reg_write(die_pkg::ADDR_ROM, 32'h00010000);
        burst_phase(40);
        drain();
        reg_write(die_pkg::ADDR_EN, 32'd1);
        reg_write(die_pkg::ADDR_ROM, 32'hFFFFFFFF);
        burst_phase(150);
        drain();

        $display("sent %0d instruction items over several memory sizes and enable settings",
                 n_sent);
        $display("ok results %0d, register errors %0d, decode errors %0d",
                 board.err_seen[die_pkg::ERR_OK], board.err_seen[die_pkg::ERR_BAD_REG],
                 board.err_seen[die_pkg::ERR_BAD_OP]);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: dsp_instruction_execute.f
sv/die_pkg.sv
sv/die_front.sv
sv/die_queue.sv
sv/die_back.sv
sv/dsp_instruction_execute.sv
sv/die_checker.sv
tb/testbench.sv
